// ===== hw/rtl/soa_pkg.sv =====
// ----------------------------------------------------------------------------
// soa_pkg
// Shared types and constants for the slab object allocator: operation and
// status codes, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package soa_pkg;

  // fixed field widths
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int SIZE_W   = 4;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT     = 2'd2;

  // register values after reset
  localparam logic [SIZE_W-1:0]  RESET_SIZE_LOG2 = 4'd6;
  localparam logic [COUNT_W-1:0] RESET_COUNT     = 7'd64;

  // request operation
  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_QUERY = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_FREE      = 3'd1,
    ST_MISALIGNED   = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_DOUBLE_FREE  = 3'd4
  } status_t;

endpackage

// ===== hw/rtl/slab_object_allocator.sv =====
// ----------------------------------------------------------------------------
// slab_object_allocator
// Object slot allocator for one slab: a queue of free slot indices and an
// in-use bit per slot; allocate, free and query requests, one result each.
// ----------------------------------------------------------------------------
//
//  channel   direction  fields (lowest bit first)
//  in_       slave      tuser: func[1:0]; tdata: address
//  out_      master     tdata: status[2:0], object_address, in_use,
//                              objects_in_use[6:0], slab_full, slab_empty
//  cfg_      write      index 0 base_address, 1 object_size_log2, 2 object_count
//
//  One request per cycle while in_tready is high. A request sits in the
//  input register after its transfer; its result is then registered in the
//  result register and offered on out_. The rate is set by the slot
//  queue and the in-use memory, each with one write and one read per cycle.
//  After reset and after each object_count write the block sweeps both
//  memories with in_tready low.
//  A stalled result holds the input register; a new request still enters
//  while the result register is being drained.
//
module slab_object_allocator #(
  parameter int NUM_OBJECTS = 64,
  parameter int ADDR_BITS   = 48
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [((ADDR_BITS+7)/8)*8-1:0]         in_tdata,   // address
  input  logic [soa_pkg::FUNC_W-1:0]             in_tuser,   // func
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // status, object_address, in_use, objects_in_use, slab_full, slab_empty
  output logic [((ADDR_BITS+13+7)/8)*8-1:0]      out_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_we,
  input  logic [soa_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ADDR_BITS-1:0]                   cfg_wdata
);
  import soa_pkg::*;

  localparam int IDX_W = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int EXT_W = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
  localparam int OUT_TDATA_W = ((ADDR_BITS + 13 + 7) / 8) * 8;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_OBJECTS - 1);
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    (NUM_OBJECTS > 127) ? 7'd127 : COUNT_W'(NUM_OBJECTS);

  // configuration registers
  logic [ADDR_BITS-1:0] base_r;
  logic [SIZE_W-1:0]    size_r;
  logic [COUNT_W-1:0]   live_r;

  // queue and slot bookkeeping
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r;
  logic [COUNT_W-1:0] free_r;
  logic               clearing_r;
  logic [IDX_W-1:0]   clr_idx_r;

  // memories
  logic [IDX_W-1:0] queue_mem [NUM_OBJECTS];
  logic             bits_mem  [NUM_OBJECTS];

  // queue head prefetch
  logic [IDX_W-1:0] q_rd_r;
  logic             q_fwd_r;
  logic [IDX_W-1:0] q_fwd_d_r;
  logic             q_we;
  logic [IDX_W-1:0] q_wa, q_wd;

  // in-use bit write port
  logic             b_we;
  logic [IDX_W-1:0] b_wa;
  logic             b_wd;

  // input register
  logic             s1_valid_r;
  func_t            s1_func_r;
  status_t          s1_loc_r;
  logic [IDX_W-1:0] s1_slot_r;
  logic             b_rd_r;
  logic             b_fwd_r;
  logic             b_fwd_d_r;

  // result register
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [ADDR_BITS-1:0] out_addr_r;
  logic                 out_in_use_r;
  logic [COUNT_W-1:0]   out_used_r;
  logic                 out_full_r;
  logic                 out_empty_r;

  // request decode
  func_t            in_func;
  logic [ADDR_BITS-1:0] in_addr;
  status_t          loc_status;
  logic [IDX_W-1:0] loc_slot;
  logic             in_fire, fire;

  // count load
  logic               count_load;
  logic [COUNT_W-1:0] count_src;
  logic [COUNT_W-1:0] live_load;
  logic [EXT_W-1:0]   live_ext;
  logic [IDX_W-1:0]   tail_load;

  // result computation
  logic [IDX_W-1:0]     head_val;
  logic                 bit_val;
  logic                 alloc_ok, free_ok;
  status_t              res_status;
  logic [ADDR_BITS-1:0] res_addr;
  logic                 res_in_use;
  logic [COUNT_W-1:0]   free_after;
  logic [COUNT_W-1:0]   used_after;

  assign in_func = func_t'(in_tuser);
  assign in_addr = in_tdata[ADDR_BITS-1:0];

  // handshake
  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clearing_r && (!s1_valid_r || fire);
  assign in_fire   = in_tvalid && in_tready;

  // address to slot
  soa_locate #(
    .ADDR_BITS (ADDR_BITS),
    .IDX_W     (IDX_W)
  ) u_locate (
    .addr      (in_addr),
    .base      (base_r),
    .size_log2 (size_r),
    .live_n    (live_r),
    .status    (loc_status),
    .slot      (loc_slot)
  );

  // object count capped at the slot capacity and at 127, on reset or register write
  assign count_load = !rst_n || (cfg_we && cfg_index == CFG_OBJECT_COUNT);
  assign count_src  = rst_n ? cfg_wdata[COUNT_W-1:0] : RESET_COUNT;
  assign live_load  = (count_src > COUNT_CAP) ? COUNT_CAP : count_src;
  assign live_ext   = EXT_W'(live_load);
  assign tail_load  = (live_ext == EXT_W'(NUM_OBJECTS)) ? '0 : live_ext[IDX_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= RESET_SIZE_LOG2;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE_ADDRESS) base_r <= cfg_wdata;
      if (cfg_index == CFG_OBJECT_SIZE_LOG2) size_r <= cfg_wdata[SIZE_W-1:0];
    end
  end

  // head slot value with write forwarding
  assign head_val = q_fwd_r ? q_fwd_d_r : q_rd_r;
  assign bit_val  = b_fwd_r ? b_fwd_d_r : b_rd_r;

  // result of the request in the input register
  always_comb begin
    alloc_ok   = 1'b0;
    free_ok    = 1'b0;
    res_status = ST_OK;
    res_addr   = '0;
    res_in_use = 1'b0;
    case (s1_func_r)
      FN_ALLOC: begin
        if (free_r == '0) begin
          res_status = ST_NO_FREE;
        end else begin
          alloc_ok = 1'b1;
          res_addr = base_r + (ADDR_BITS'(head_val) << size_r);
        end
      end
      FN_FREE: begin
        if (s1_loc_r != ST_OK) begin
          res_status = s1_loc_r;
        end else if (!bit_val) begin
          res_status = ST_DOUBLE_FREE;
        end else begin
          free_ok = 1'b1;
        end
      end
      FN_QUERY: begin
        res_status = s1_loc_r;
        res_in_use = (s1_loc_r == ST_OK) && bit_val;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // counts after the operation
  always_comb begin
    free_after = free_r;
    if (alloc_ok) free_after = free_r - 1'b1;
    if (free_ok)  free_after = free_r + 1'b1;
    used_after = (live_r >= free_after) ? live_r - free_after : '0;
  end

  // next head index
  always_comb begin
    head_nxt = head_r;
    if (count_load) begin
      head_nxt = '0;
    end else if (fire && alloc_ok) begin
      head_nxt = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    end
  end

  // memory write ports: sweep, or the retiring request
  always_comb begin
    q_we = clearing_r || (fire && free_ok);
    q_wa = clearing_r ? clr_idx_r : tail_r;
    q_wd = clearing_r ? clr_idx_r : s1_slot_r;
    b_we = clearing_r || (fire && (alloc_ok || free_ok));
    b_wa = clearing_r ? clr_idx_r : (alloc_ok ? head_val : s1_slot_r);
    b_wd = !clearing_r && alloc_ok;
  end

  // slot queue
  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_wa] <= q_wd;
    q_rd_r    <= queue_mem[head_nxt];
    q_fwd_r   <= q_we && (q_wa == head_nxt);
    q_fwd_d_r <= q_wd;
  end

  // in-use bits, read when a request enters
  always_ff @(posedge clk) begin
    if (b_we) bits_mem[b_wa] <= b_wd;
    if (in_fire) begin
      b_rd_r    <= bits_mem[loc_slot];
      b_fwd_r   <= b_we && (b_wa == loc_slot);
      b_fwd_d_r <= b_wd;
    end
  end

  // queue pointers, free count and sweep
  always_ff @(posedge clk) begin
    if (count_load) begin
      live_r     <= live_load;
      head_r     <= '0;
      tail_r     <= tail_load;
      free_r     <= live_load;
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      head_r <= head_nxt;
      if (fire) free_r <= free_after;
      if (fire && free_ok) tail_r <= (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) clearing_r <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= in_func;
      s1_loc_r  <= loc_status;
      s1_slot_r <= loc_slot;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
      out_in_use_r <= res_in_use;
      out_used_r   <= used_after;
      out_full_r   <= (free_after == '0);
      out_empty_r  <= (used_after == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_empty_r, out_full_r, out_used_r, out_in_use_r,
                                    out_addr_r, out_status_r});

endmodule

// ===== hw/rtl/soa_locate.sv =====
// ----------------------------------------------------------------------------
// soa_locate
// Maps an object address to its slot: boundary check, then range check
// against the live object count.
// ----------------------------------------------------------------------------
module soa_locate #(
  parameter int ADDR_BITS = 48,
  parameter int IDX_W     = 6
) (
  input  logic [ADDR_BITS-1:0]        addr,
  input  logic [ADDR_BITS-1:0]        base,
  input  logic [soa_pkg::SIZE_W-1:0]  size_log2,
  input  logic [soa_pkg::COUNT_W-1:0] live_n,
  output soa_pkg::status_t            status,
  output logic [IDX_W-1:0]            slot
);
  import soa_pkg::*;

  logic [ADDR_BITS-1:0] offset;
  logic [ADDR_BITS-1:0] low_mask;
  logic [ADDR_BITS-1:0] idx;

  // offset from the slab start wraps with the address width
  assign offset   = addr - base;
  assign low_mask = ~({ADDR_BITS{1'b1}} << size_log2);
  assign idx      = offset >> size_log2;
  assign slot     = idx[IDX_W-1:0];

  // boundary check first, then range
  always_comb begin
    if ((offset & low_mask) != '0) begin
      status = ST_MISALIGNED;
    end else if (idx >= ADDR_BITS'(live_n)) begin
      status = ST_OUT_OF_RANGE;
    end else begin
      status = ST_OK;
    end
  end

endmodule
